// ===== rtl/rarc_pkg.sv =====
// Shared types and constants for the reed array run centroid block.
`timescale 1ns / 1ps

package rarc_pkg;

    localparam int MAX_SENSORS_DEF = 16;
    localparam int FIFO_DEPTH_DEF  = 4;

    localparam int RAW_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int RES_W    = 16;
    localparam int OFFSET_W = 9;
    localparam int CENTER_W = 5;
    localparam int IDX_W    = 3;
    localparam int LAT_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LAT_LIMIT = 10354530;

    localparam logic [COUNT_W-1:0]  SENSOR_COUNT_RST  = COUNT_W'(8);
    localparam logic                ACTIVE_LEVEL_RST  = 1'b0;
    localparam logic [RES_W-1:0]    RESOLUTION_RST    = RES_W'(2560);
    localparam logic [OFFSET_W-1:0] OFFSET_HALF_RST   = OFFSET_W'(9);

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_HALF  = 3'd3;

    typedef struct packed {
        logic [COUNT_W-1:0]         sensor_count;
        logic                       active_level;
        logic [RES_W-1:0]           resolution_q8;
        logic signed [OFFSET_W-1:0] offset_half;
    } cfg_t;

    // One run found by the front end, waiting for its position to be scaled.
    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [IDX_W-1:0]    index;
        logic                last;
    } run_desc_t;

endpackage

// ===== rtl/rarc_fifo.sv =====
// Small register queue of run descriptors between the front and back ends.
`timescale 1ns / 1ps

module rarc_fifo #(
    parameter int DEPTH = rarc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rarc_pkg::run_desc_t   push_data,
    output logic                  full,
    input  logic                  pop,
    output rarc_pkg::run_desc_t   pop_data,
    output logic                  empty
);
    import rarc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_desc_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("run queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("run queue read while empty");

endmodule

// ===== rtl/rarc_front.sv =====
// Front end: accepts switch words and peels off one active run per cycle while the run queue has room.
`timescale 1ns / 1ps

module rarc_front #(
    parameter int MAX_SENSORS = rarc_pkg::MAX_SENSORS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rarc_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rarc_pkg::RAW_W-1:0]  raw_bits,
    output logic                        push,
    output rarc_pkg::run_desc_t         push_data,
    input  logic                        fifo_full
);
    import rarc_pkg::*;

    localparam int SIDX_W = $clog2(MAX_SENSORS);

    logic                   busy_reg, busy_next;
    logic [MAX_SENSORS-1:0] act_reg, act_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    logic [MAX_SENSORS-1:0] act_in;
    logic [MAX_SENSORS-1:0] lowbit;
    logic [MAX_SENSORS-1:0] run_sum;
    logic [MAX_SENSORS-1:0] run_bits;
    logic [MAX_SENSORS-1:0] remain;
    logic [SIDX_W-1:0]      first_idx;
    logic [SIDX_W-1:0]      last_idx;
    logic                   accept;

    // Bits at or above sensor_count are forced inactive, which also pads the top end.
    always_comb
    begin
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            act_in[i] = (raw_bits[i] == cfg.active_level) && (COUNT_W'(i) < cfg.sensor_count);
        end
    end

    // Adding the lowest set bit clears the lowest run; the cleared bits are that run.
    assign lowbit   = act_reg & (~act_reg + 1'b1);
    assign run_sum  = act_reg + lowbit;
    assign run_bits = act_reg & ~run_sum;
    assign remain   = act_reg & run_sum;

    always_comb
    begin
        first_idx = '0;
        last_idx  = '0;
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            if (lowbit[i])
            begin
                first_idx = SIDX_W'(i);
            end
            if (run_bits[i])
            begin
                last_idx = SIDX_W'(i);
            end
        end
    end

    assign push               = busy_reg && !fifo_full;
    assign push_data.center   = CENTER_W'(first_idx) + CENTER_W'(last_idx);
    assign push_data.index    = idx_reg;
    assign push_data.last     = (remain == '0);

    assign in_stall = busy_reg && !(push && remain == '0);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        act_next  = act_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            busy_next = (act_in != '0);
            act_next  = act_in;
            idx_next  = '0;
        end
        else if (push)
        begin
            busy_next = (remain != '0);
            act_next  = remain;
            idx_next  = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            act_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            act_reg  <= act_next;
            idx_reg  <= idx_next;
        end
    end

    a_busy_has_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (act_reg != '0))
        else $error("front end busy with no active run left");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.last) |-> !in_stall)
        else $error("input stalled while last run of a word is handed on");

endmodule

// ===== rtl/rarc_back.sv =====
// Back end: scales run centers into lateral positions and holds the output word.
`timescale 1ns / 1ps

module rarc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rarc_pkg::cfg_t                       cfg,
    input  logic                                 fifo_empty,
    input  rarc_pkg::run_desc_t                  fifo_data,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rarc_pkg::CENTER_W-1:0]        run_center_half,
    output logic signed [rarc_pkg::LAT_W-1:0]    lateral_pos,
    output logic [rarc_pkg::IDX_W-1:0]           run_index,
    output logic                                 last
);
    import rarc_pkg::*;

    localparam int DIFF_W = OFFSET_W + 1;
    localparam int PROD_W = RES_W + 1 + DIFF_W;

    logic                       out_valid_reg, out_valid_next;
    logic [CENTER_W-1:0]        center_reg;
    logic signed [LAT_W-1:0]    lat_reg;
    logic [IDX_W-1:0]           index_reg;
    logic                       last_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   product;
    logic signed [LAT_W-1:0]    lat_sat;

    assign pop = !fifo_empty && (!out_valid_reg || !out_stall);

    assign diff    = $signed({{(DIFF_W - CENTER_W){1'b0}}, fifo_data.center})
                   - $signed({cfg.offset_half[OFFSET_W-1], cfg.offset_half});
    assign product = $signed({1'b0, cfg.resolution_q8}) * diff;

    always_comb
    begin
        if (product > PROD_W'(LAT_LIMIT))
        begin
            lat_sat = LAT_W'(LAT_LIMIT);
        end
        else if (product < -PROD_W'(LAT_LIMIT))
        begin
            lat_sat = -LAT_W'(LAT_LIMIT);
        end
        else
        begin
            lat_sat = product[LAT_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            center_reg <= fifo_data.center;
            lat_reg    <= lat_sat;
            index_reg  <= fifo_data.index;
            last_reg   <= fifo_data.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign run_center_half = center_reg;
    assign lateral_pos     = lat_reg;
    assign run_index       = index_reg;
    assign last            = last_reg;

    a_valid_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pop))
        else $error("output word appeared without a queue read");

endmodule

// ===== rtl/reed_array_run_centroid_top.sv =====
// Top level of the reed array run centroid block: registers and wiring.
`timescale 1ns / 1ps

// The block takes one switch word per input handshake (in_valid / in_stall,
// raw_bits) and returns one output word per active run in it, lowest switch
// first, with run_index counting from zero and last set on the final run. A
// word with no active run produces nothing. Settings are written through the
// cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data); cfg_ready is always
// high, and writes are expected only while no word is in flight.
//
// The front end extracts one run per cycle while the run queue has room, so a
// word occupies the input until the last of its runs has been queued.
// A new word is taken in the same cycle that the last run of the previous word
// is queued. The first result of a word is registered in the run extractor,
// then in the run queue and then in the output register. After that, one
// result can leave per cycle while the receiver does not stall.
//
// Reset returns the settings to their defaults (8 switches, active low,
// 10.0 switch spacing, offset 9 half switches) and empties the queue. When the
// receiver stalls, the output word holds, the queue fills, and then the input
// stalls; no result is lost or repeated.

module reed_array_run_centroid_top #(
    parameter int MAX_SENSORS = rarc_pkg::MAX_SENSORS_DEF,
    parameter int FIFO_DEPTH  = rarc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rarc_pkg::RAW_W-1:0]           raw_bits,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rarc_pkg::CENTER_W-1:0]        run_center_half,
    output logic signed [rarc_pkg::LAT_W-1:0]    lateral_pos,
    output logic [rarc_pkg::IDX_W-1:0]           run_index,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rarc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rarc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rarc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       push;
    run_desc_t  push_data;
    logic       fifo_full;
    logic       pop;
    run_desc_t  pop_data;
    logic       fifo_empty;

    assign cfg_ready = 1'b1;

    // Writes to an index past the last register fall into the default arm.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SENSOR_COUNT: cfg_next.sensor_count  = cfg_data[COUNT_W-1:0];
                REG_ACTIVE_LEVEL: cfg_next.active_level  = cfg_data[0];
                REG_RESOLUTION:   cfg_next.resolution_q8 = cfg_data[RES_W-1:0];
                REG_OFFSET_HALF:  cfg_next.offset_half   = $signed(cfg_data[OFFSET_W-1:0]);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_count  <= SENSOR_COUNT_RST;
            cfg_reg.active_level  <= ACTIVE_LEVEL_RST;
            cfg_reg.resolution_q8 <= RESOLUTION_RST;
            cfg_reg.offset_half   <= $signed(OFFSET_HALF_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rarc_front #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_bits  (raw_bits),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    rarc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    rarc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .fifo_empty      (fifo_empty),
        .fifo_data       (pop_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .run_center_half (run_center_half),
        .lateral_pos     (lateral_pos),
        .run_index       (run_index),
        .last            (last)
    );

endmodule
